>>> hdl/q2e_pkg.sv
// shared types, constants and helper functions of the quaternion to euler block
package q2e_pkg;

  localparam int unsigned TAB_SIZE = 24;
  localparam int unsigned SQRT_STEPS = 32;

  localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;
  localparam logic signed [35:0] MAT_LIM = 36'sd1073741824;
  localparam logic signed [23:0] PI_Q20 = 24'sd3294199;
  localparam logic signed [24:0] HALF_PI_Q20 = 25'sd1647099;
  localparam logic signed [16:0] ANGLE_LIM = 17'sd12868;

  typedef struct packed {
    logic signed [33:0] xx;
    logic signed [33:0] xy;
    logic signed [33:0] xz;
    logic signed [33:0] yy;
    logic signed [33:0] yz;
    logic signed [33:0] zz;
    logic signed [33:0] wx;
    logic signed [33:0] wy;
    logic signed [33:0] wz;
  } prod_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m22;
    logic               lock;
  } mat_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [23:0] z;
  } cvec_t;

  typedef struct packed {
    logic lock;
    logic m02_neg;
  } side_t;

  function automatic logic signed [31:0] sat_mat(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > MAT_LIM) begin
      r = 32'sd1073741824;
    end else if (v < -MAT_LIM) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] atan_q20(input int unsigned i);
    logic signed [23:0] r;
    case (i)
      0:       r = 24'sd823550;
      1:       r = 24'sd486170;
      2:       r = 24'sd256879;
      3:       r = 24'sd130396;
      4:       r = 24'sd65451;
      5:       r = 24'sd32757;
      6:       r = 24'sd16383;
      7:       r = 24'sd8192;
      8:       r = 24'sd4096;
      9:       r = 24'sd2048;
      10:      r = 24'sd1024;
      11:      r = 24'sd512;
      12:      r = 24'sd256;
      13:      r = 24'sd128;
      14:      r = 24'sd64;
      15:      r = 24'sd32;
      16:      r = 24'sd16;
      17:      r = 24'sd8;
      18:      r = 24'sd4;
      19:      r = 24'sd2;
      20:      r = 24'sd1;
      default: r = 24'sd0;
    endcase
    return r;
  endfunction

  function automatic cvec_t cordic_prep(input logic signed [31:0] y,
                                        input logic signed [33:0] x);
    cvec_t r;
    if (x < 0) begin
      r.x = -x;
      r.y = -34'(y);
      r.z = (y >= 0) ? PI_Q20 : -PI_Q20;
    end else begin
      r.x = x;
      r.y = 34'(y);
      r.z = 24'sd0;
    end
    return r;
  endfunction

  function automatic cvec_t cordic_step(input cvec_t v, input int unsigned i);
    cvec_t r;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    xs = v.x >>> i;
    ys = v.y >>> i;
    r = v;
    if (v.y > 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + atan_q20(i);
    end else if (v.y < 0) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - atan_q20(i);
    end
    return r;
  endfunction

  function automatic logic signed [14:0] to_out(input logic signed [24:0] a);
    logic signed [24:0] t;
    logic signed [16:0] r;
    t = a + 25'sd128;
    r = 17'(t >>> 8);
    if (r > ANGLE_LIM) begin
      r = ANGLE_LIM;
    end else if (r < -ANGLE_LIM) begin
      r = -ANGLE_LIM;
    end
    return r[14:0];
  endfunction

endpackage

>>> hdl/q2e_quat_if.sv
// input channel: one quaternion word
interface q2e_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y,
                input quat_z, output ready);
endinterface

>>> hdl/q2e_euler_if.sv
// output channel: one euler angle word
interface q2e_euler_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_angle;
  logic signed [14:0] yaw_angle;
  logic signed [14:0] roll_angle;
  logic               gimbal_lock;

  modport source (output valid, output pitch_angle, output yaw_angle,
                  output roll_angle, output gimbal_lock, input ready);
  modport sink (input valid, input pitch_angle, input yaw_angle,
                input roll_angle, input gimbal_lock, output ready);
endinterface

>>> hdl/quaternion_to_euler_angles.sv
// top level: pipelined quaternion to yaw, pitch and roll conversion
//
// quat_i takes one unit quaternion word (Q1.14) per cycle when valid and
// ready are both high; euler_o returns pitch, yaw and roll in Q2.12 radians
// plus the gimbal lock flag, one word per input word, in order.
// The path is a chain of register stages: products, matrix terms, squares,
// sum, 32 one-bit steps of the integer square root, operand setup, one stage
// per CORDIC iteration (min(CORDIC_STAGES, 24)) and the output register.
// The throughput is one word per cycle while the receiver takes words on euler_o.
// Each stage has its own valid bit and takes a new word whenever it is empty
// or its successor moves, so bubbles close up while the receiver stalls and
// nothing is dropped or repeated; input ready falls only once every stage
// holds a word.
// Reset clears all valid bits; the pipeline is empty afterwards.
module quaternion_to_euler_angles
  import q2e_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  q2e_quat_if.sink     quat_i,
  q2e_euler_if.source  euler_o
);

  localparam int unsigned NC = (CORDIC_STAGES > TAB_SIZE) ? TAB_SIZE : CORDIC_STAGES;
  localparam int unsigned ST_SQRT = 4;
  localparam int unsigned ST_PREP = ST_SQRT + SQRT_STEPS;
  localparam int unsigned ST_OUT = ST_PREP + NC + 1;
  localparam int unsigned NST = ST_OUT + 1;

  logic [NST-1:0] v_q;
  logic [NST-1:0] v_in;
  logic [NST:0]   en;

  prod_t       prod_q;
  mat_t        mat_q;
  mat_t        sq_m_q;
  logic [61:0] sq0_q;
  logic [61:0] sq1_q;
  mat_t        sum_m_q;
  logic [63:0] sum_q;

  logic [63:0] rt_n_q [SQRT_STEPS];
  logic [63:0] rt_r_q [SQRT_STEPS];
  mat_t        rt_m_q [SQRT_STEPS];

  cvec_t cv_q [NC+1][3];
  side_t sd_q [NC+1];

  assign en[NST] = euler_o.ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = ~v_q[i] | en[i+1];
  end
  assign quat_i.ready = en[0];
  assign euler_o.valid = v_q[NST-1];
  assign v_in = {v_q[NST-2:0], quat_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  // products of doubled components
  logic signed [16:0] w_e, x_e, y_e, z_e, x2, y2, z2;
  prod_t prod_d;
  assign w_e = 17'(quat_i.quat_w);
  assign x_e = 17'(quat_i.quat_x);
  assign y_e = 17'(quat_i.quat_y);
  assign z_e = 17'(quat_i.quat_z);
  assign x2 = x_e <<< 1;
  assign y2 = y_e <<< 1;
  assign z2 = z_e <<< 1;
  assign prod_d.xx = 34'(x_e) * 34'(x2);
  assign prod_d.xy = 34'(x_e) * 34'(y2);
  assign prod_d.xz = 34'(x_e) * 34'(z2);
  assign prod_d.yy = 34'(y_e) * 34'(y2);
  assign prod_d.yz = 34'(y_e) * 34'(z2);
  assign prod_d.zz = 34'(z_e) * 34'(z2);
  assign prod_d.wx = 34'(w_e) * 34'(x2);
  assign prod_d.wy = 34'(w_e) * 34'(y2);
  assign prod_d.wz = 34'(w_e) * 34'(z2);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= prod_d;
    end
  end

  // matrix terms
  mat_t mat_d;
  always_comb begin
    mat_d.m00 = sat_mat(ONE_Q28 - (36'(prod_q.yy) + 36'(prod_q.zz)));
    mat_d.m01 = sat_mat(36'(prod_q.xy) - 36'(prod_q.wz));
    mat_d.m02 = sat_mat(36'(prod_q.xz) + 36'(prod_q.wy));
    mat_d.m10 = sat_mat(36'(prod_q.xy) + 36'(prod_q.wz));
    mat_d.m11 = sat_mat(ONE_Q28 - (36'(prod_q.xx) + 36'(prod_q.zz)));
    mat_d.m12 = sat_mat(36'(prod_q.yz) - 36'(prod_q.wx));
    mat_d.m22 = sat_mat(ONE_Q28 - (36'(prod_q.xx) + 36'(prod_q.yy)));
    mat_d.lock = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mat_q <= mat_d;
    end
  end

  // squares and lock detect
  logic signed [63:0] sq0_d, sq1_d;
  mat_t               sq_m_d;
  assign sq0_d = 64'(mat_q.m00) * 64'(mat_q.m00);
  assign sq1_d = 64'(mat_q.m01) * 64'(mat_q.m01);

  always_comb begin
    sq_m_d      = mat_q;
    sq_m_d.lock = (mat_q.m00 == '0) && (mat_q.m01 == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sq0_q  <= sq0_d[61:0];
      sq1_q  <= sq1_d[61:0];
      sq_m_q <= sq_m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sum_q   <= 64'(sq0_q) + 64'(sq1_q);
      sum_m_q <= sq_m_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - j));
    logic [63:0] n_in, r_in, trial;
    mat_t        m_in;
    if (j == 0) begin : g_first
      assign n_in = sum_q;
      assign r_in = '0;
      assign m_in = sum_m_q;
    end else begin : g_next
      assign n_in = rt_n_q[j-1];
      assign r_in = rt_r_q[j-1];
      assign m_in = rt_m_q[j-1];
    end
    assign trial = r_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en[ST_SQRT+j]) begin
        rt_m_q[j] <= m_in;
        if (n_in >= trial) begin
          rt_n_q[j] <= n_in - trial;
          rt_r_q[j] <= (r_in >> 1) + BIT;
        end else begin
          rt_n_q[j] <= n_in;
          rt_r_q[j] <= r_in >> 1;
        end
      end
    end
  end

  // operand setup for the three atan2 channels
  mat_t               mf;
  logic signed [33:0] s_e;
  assign mf = rt_m_q[SQRT_STEPS-1];
  assign s_e = 34'(rt_r_q[SQRT_STEPS-1][32:0]);

  always_ff @(posedge clk_i) begin
    if (en[ST_PREP]) begin
      cv_q[0][0] <= cordic_prep(mf.m02, s_e);
      cv_q[0][1] <= mf.lock ? cordic_prep(mf.m10, 34'(mf.m11))
                            : cordic_prep(mf.m01, 34'(mf.m00));
      cv_q[0][2] <= cordic_prep(mf.m12, 34'(mf.m22));
      sd_q[0]    <= side_t'{lock: mf.lock, m02_neg: (mf.m02 < 0)};
    end
  end

  for (genvar c = 1; c <= NC; c++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en[ST_PREP+c]) begin
        for (int k = 0; k < 3; k++) begin
          cv_q[c][k] <= cordic_step(cv_q[c-1][k], c - 1);
        end
        sd_q[c] <= sd_q[c-1];
      end
    end
  end

  // sign, gimbal lock selection, rounding and clamp
  logic signed [24:0] zp, zy, zr, pitch_a, yaw_a, roll_a;
  assign zp = 25'(cv_q[NC][0].z);
  assign zy = 25'(cv_q[NC][1].z);
  assign zr = 25'(cv_q[NC][2].z);
  assign pitch_a = sd_q[NC].lock ? (sd_q[NC].m02_neg ? HALF_PI_Q20 : -HALF_PI_Q20) : -zp;
  assign yaw_a = sd_q[NC].lock ? -zy : zy;
  assign roll_a = sd_q[NC].lock ? 25'sd0 : zr;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      euler_o.pitch_angle <= to_out(pitch_a);
      euler_o.yaw_angle   <= to_out(yaw_a);
      euler_o.roll_angle  <= to_out(roll_a);
      euler_o.gimbal_lock <= sd_q[NC].lock;
    end
  end

endmodule
